// ----- design/bole_pkg.sv -----
`default_nettype none

package bole_pkg;

  localparam int unsigned ActionW  = 3;
  localparam int unsigned PosW     = 5;
  localparam int unsigned ValueW   = 32;
  localparam int unsigned StatusW  = 3;
  localparam int unsigned CountW   = 5;
  localparam int unsigned InDataW  = 72;
  localparam int unsigned OutDataW = 40;

  typedef enum logic [ActionW-1:0] {
    ACT_APPEND = 3'd0,
    ACT_REMOVE = 3'd1,
    ACT_INSERT = 3'd2,
    ACT_DELETE = 3'd3,
    ACT_EDIT   = 3'd4
  } action_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_RANGE    = 3'd2,
    ST_FULL     = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_e;

  localparam logic [ValueW-1:0] RemovedEmpty = '1;

endpackage

`default_nettype wire

// ----- design/bounded_ordered_list_engine_top.sv -----
// sequencing: append, failed requests, unknown actions, insert at the end and delete of the
//   last entry go from the execute state straight to the finish state; shifts and searches
//   move or compare one entry per cycle, and remove and insert add a step for the head read or
//   the new value write; the result loads in the finish state once the output register is free
// throughput: one request at a time, the next beat is taken the cycle after the result loads
// reset clears the entry count and the sequencer; entry memory is not cleared
`default_nettype none

module bounded_ordered_list_engine_top #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // action, position, value, new_value
  input  wire logic [bole_pkg::InDataW-1:0]   s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // status, removed_value, entry_count
  output logic [bole_pkg::OutDataW-1:0]       m_axis_tdata
);

  localparam int unsigned CntW  = $clog2(DEPTH + 1);
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CmpW  = (CntW > bole_pkg::PosW) ? CntW : bole_pkg::PosW;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_HEAD,
    S_UP,
    S_WRVAL,
    S_DOWN,
    S_SEARCH,
    S_FINISH
  } state_e;

  state_e                          state_q, state_d;
  logic [CntW-1:0]                 count_q, count_d;
  logic [AddrW-1:0]                ptr_q, ptr_d;
  bole_pkg::action_e               act_q;
  logic [bole_pkg::PosW-1:0]       pos_q;
  logic [bole_pkg::ValueW-1:0]     val_q;
  logic [bole_pkg::ValueW-1:0]     nval_q;
  bole_pkg::status_e               sts_q, sts_d;
  logic [bole_pkg::ValueW-1:0]     rem_q, rem_d;
  logic                            m_valid_q, m_valid_d;
  bole_pkg::status_e               o_sts_q;
  logic [bole_pkg::ValueW-1:0]     o_rem_q;
  logic [bole_pkg::CountW-1:0]     o_cnt_q;

  logic [bole_pkg::ValueW-1:0]     mem [DEPTH];
  logic [bole_pkg::ValueW-1:0]     rd_data_q;
  logic                            we, re;
  logic [AddrW-1:0]                wa, ra;
  logic [bole_pkg::ValueW-1:0]     wd;

  logic                            accept, out_load;
  logic                            empty, full;
  logic [CmpW-1:0]                 pos_ext, cnt_ext;
  logic [AddrW-1:0]                pos_addr, cnt_addr, cnt_m1;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {o_cnt_q, o_rem_q, o_sts_q};

  assign empty    = (count_q == '0);
  assign full     = (count_q == CntW'(DEPTH));
  assign pos_ext  = CmpW'(pos_q);
  assign cnt_ext  = CmpW'(count_q);
  assign pos_addr = AddrW'(pos_ext);
  assign cnt_addr = AddrW'(count_q);
  assign cnt_m1   = AddrW'(count_q - CntW'(1));

  assign out_load = (state_q == S_FINISH) && (!m_valid_q || m_axis_tready);

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    ptr_d     = ptr_q;
    sts_d     = sts_q;
    rem_d     = rem_q;
    we        = 1'b0;
    wa        = ptr_q;
    wd        = rd_data_q;
    re        = 1'b0;
    ra        = ptr_q;
    m_valid_d = m_valid_q;
    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
          sts_d   = bole_pkg::ST_OK;
          rem_d   = '0;
        end
      end
      S_EXEC: begin
        state_d = S_FINISH;
        case (act_q)
          bole_pkg::ACT_APPEND: begin
            if (full) begin
              sts_d = bole_pkg::ST_FULL;
            end else begin
              we      = 1'b1;
              wa      = cnt_addr;
              wd      = val_q;
              count_d = count_q + CntW'(1);
            end
          end
          bole_pkg::ACT_REMOVE: begin
            if (empty) begin
              sts_d = bole_pkg::ST_EMPTY;
              rem_d = bole_pkg::RemovedEmpty;
            end else begin
              re      = 1'b1;
              ra      = '0;
              state_d = S_HEAD;
            end
          end
          bole_pkg::ACT_INSERT: begin
            if (empty) begin
              sts_d = bole_pkg::ST_EMPTY;
            end else if (pos_ext > cnt_ext) begin
              sts_d = bole_pkg::ST_RANGE;
            end else if (full) begin
              sts_d = bole_pkg::ST_FULL;
            end else if (pos_ext == cnt_ext) begin
              we      = 1'b1;
              wa      = pos_addr;
              wd      = val_q;
              count_d = count_q + CntW'(1);
            end else begin
              re      = 1'b1;
              ra      = cnt_m1;
              ptr_d   = cnt_m1;
              state_d = S_UP;
            end
          end
          bole_pkg::ACT_DELETE: begin
            if (empty) begin
              sts_d = bole_pkg::ST_EMPTY;
            end else if (pos_ext >= cnt_ext) begin
              sts_d = bole_pkg::ST_RANGE;
            end else if (pos_addr == cnt_m1) begin
              count_d = count_q - CntW'(1);
            end else begin
              re      = 1'b1;
              ra      = pos_addr + AddrW'(1);
              ptr_d   = pos_addr + AddrW'(1);
              state_d = S_DOWN;
            end
          end
          bole_pkg::ACT_EDIT: begin
            if (empty) begin
              sts_d = bole_pkg::ST_NOTFOUND;
            end else begin
              re      = 1'b1;
              ra      = '0;
              ptr_d   = '0;
              state_d = S_SEARCH;
            end
          end
          default: begin
            sts_d = bole_pkg::ST_OK;
          end
        endcase
      end
      S_HEAD: begin
        rem_d = rd_data_q;
        if (count_q == CntW'(1)) begin
          count_d = '0;
          state_d = S_FINISH;
        end else begin
          re      = 1'b1;
          ra      = AddrW'(1);
          ptr_d   = AddrW'(1);
          state_d = S_DOWN;
        end
      end
      S_UP: begin
        we = 1'b1;
        wa = ptr_q + AddrW'(1);
        wd = rd_data_q;
        if (ptr_q == pos_addr) begin
          state_d = S_WRVAL;
        end else begin
          re    = 1'b1;
          ra    = ptr_q - AddrW'(1);
          ptr_d = ptr_q - AddrW'(1);
        end
      end
      S_WRVAL: begin
        we      = 1'b1;
        wa      = pos_addr;
        wd      = val_q;
        count_d = count_q + CntW'(1);
        state_d = S_FINISH;
      end
      S_DOWN: begin
        we = 1'b1;
        wa = ptr_q - AddrW'(1);
        wd = rd_data_q;
        if (ptr_q == cnt_m1) begin
          count_d = count_q - CntW'(1);
          state_d = S_FINISH;
        end else begin
          re    = 1'b1;
          ra    = ptr_q + AddrW'(1);
          ptr_d = ptr_q + AddrW'(1);
        end
      end
      S_SEARCH: begin
        if (rd_data_q == val_q) begin
          we      = 1'b1;
          wa      = ptr_q;
          wd      = nval_q;
          sts_d   = bole_pkg::ST_OK;
          state_d = S_FINISH;
        end else if (ptr_q == cnt_m1) begin
          sts_d   = bole_pkg::ST_NOTFOUND;
          state_d = S_FINISH;
        end else begin
          re    = 1'b1;
          ra    = ptr_q + AddrW'(1);
          ptr_d = ptr_q + AddrW'(1);
        end
      end
      S_FINISH: begin
        if (out_load) begin
          m_valid_d = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      ptr_q     <= '0;
      sts_q     <= bole_pkg::ST_OK;
      rem_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      ptr_q     <= ptr_d;
      sts_q     <= sts_d;
      rem_q     <= rem_d;
      m_valid_q <= m_valid_d;
    end
  end

  // request and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q  <= bole_pkg::action_e'(s_axis_tdata[2:0]);
      pos_q  <= s_axis_tdata[7:3];
      val_q  <= s_axis_tdata[39:8];
      nval_q <= s_axis_tdata[71:40];
    end
    if (out_load) begin
      o_sts_q <= sts_q;
      o_rem_q <= rem_q;
      o_cnt_q <= bole_pkg::CountW'(count_q);
    end
  end

  // entry memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_data_q <= mem[ra];
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("entry count above depth");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == $past(count_q)) || (count_q == $past(count_q) + CntW'(1)) ||
    (count_q + CntW'(1) == $past(count_q)))
    else $error("entry count moved by more than one");

  a_read_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    re |-> (CntW'(ra) < count_q))
    else $error("read of an entry beyond the list");

  a_write_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (CntW'(wa) < CntW'(DEPTH)))
    else $error("write beyond the memory");

  a_count_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |=> (count_q == $past(count_q)))
    else $error("entry count changed with no request in work");
`endif

endmodule

`default_nettype wire
